@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the stream filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define SFOF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sfof assertion failed");
// Expression must never be true outside reset.
`define SFOF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("sfof forbidden condition seen");
`else
`define SFOF_ASSERT(lbl, clk, rst_n, prop)
`define SFOF_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/sfof_pkg.sv @@
// ----------------------------------------------------------------------------
// sfof_pkg
// Shared constants and controller/datapath interface types of the filter.
// ----------------------------------------------------------------------------
package sfof_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths of the item ports.
	localparam int VALUE_W = 32;
	localparam int POS_W   = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic commit;
	} sfof_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic out_free;
	} sfof_sts_t;

endpackage

@@ rtl/sfof_datapath.sv @@
// ----------------------------------------------------------------------------
// sfof_datapath
// Input register, table of distinct values with parallel compare, entry
// count and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfof_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sfof_pkg::sfof_cmd_t            cmd,
	output sfof_pkg::sfof_sts_t            sts,
	input  logic signed [sfof_pkg::VALUE_W-1:0] sample_value,
	input  logic                           new_set,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [sfof_pkg::VALUE_W-1:0] unique_value,
	output logic [sfof_pkg::POS_W-1:0]     unique_position,
	output logic                           table_overflow
);
	import sfof_pkg::*;

	logic signed [VALUE_W-1:0] sample_q;
	logic                      new_set_q;
	logic [VALUE_W-1:0]        seen_q [TABLE_DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          eff_count;
	logic [TABLE_DEPTH-1:0]    match;
	logic                      full;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] unique_value_q;
	logic [POS_W-1:0]          unique_position_q;
	logic                      table_overflow_q;

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q  <= sample_value;
			new_set_q <= new_set;
		end
	end

	// A new set starts with an empty table.
	assign eff_count = new_set_q ? '0 : count_q;
	assign full      = (eff_count == CNT_W'(TABLE_DEPTH));

	// Compare against every entry in use at once.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = (CNT_W'(i) < eff_count) && (seen_q[i] == sample_q);
		end
	end

	assign sts.hit      = |match;
	assign sts.out_free = !out_valid_q || !out_stall;

	// Store a new distinct value while there is room.
	always_ff @(posedge clk) begin
		if (cmd.commit && !full) begin
			seen_q[eff_count[IDX_W-1:0]] <= sample_q;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= full ? eff_count : eff_count + CNT_W'(1);
		end
	end

	// Output register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			unique_value_q    <= sample_q;
			unique_position_q <= POS_W'(eff_count);
			table_overflow_q  <= full;
		end
	end

	assign out_valid       = out_valid_q;
	assign unique_value    = unique_value_q;
	assign unique_position = unique_position_q;
	assign table_overflow  = table_overflow_q;

	// The count never runs past the table size.
	`SFOF_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(TABLE_DEPTH))
	// A result is never written over one that is still waiting.
	`SFOF_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.commit && out_valid_q && out_stall)
	// A committed item shows up as a result in the next cycle.
	`SFOF_ASSERT(a_commit_shows, clk, arst_n, cmd.commit |=> out_valid_q)

endmodule

@@ rtl/sfof_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfof_ctrl
// Two-state controller: accept an item, then drop it as a repeat or commit it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfof_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sfof_pkg::sfof_sts_t sts,
	output sfof_pkg::sfof_cmd_t cmd
);
	import sfof_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_CHECK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// Accept only while idle.
	assign in_stall = (state_q != ST_IDLE);

	// Load strobe, next state and commit decision.
	always_comb begin
		state_d     = state_q;
		cmd.load_in = in_valid && (state_q == ST_IDLE);
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.hit) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A repeat is never committed.
	`SFOF_ASSERT_NEVER(a_no_commit_on_hit, clk, arst_n, cmd.commit && sts.hit)
	// An accepted item is checked in the following cycle.
	`SFOF_ASSERT(a_load_then_check, clk, arst_n, cmd.load_in |=> (state_q == ST_CHECK))
	// Commits happen only in the check state.
	`SFOF_ASSERT(a_commit_in_check, clk, arst_n, cmd.commit |-> (state_q == ST_CHECK))

endmodule

@@ rtl/stream_first_occurrence_filter_top.sv @@
// A passed item goes through the input register and then the output register.
// Each item is accepted, then compared and committed or dropped, before
// another is taken; a result that blocks the output register holds the commit.
// The compare against all stored entries is combinational and parallel.
// Reset clears the controller, the entry count and the output valid flag.
// ----------------------------------------------------------------------------
// stream_first_occurrence_filter_top
// Passes first occurrences of values in a set; drops repeats of stored values.
// ----------------------------------------------------------------------------
module stream_first_occurrence_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sfof_pkg::VALUE_W-1:0] sample_value,
	input  logic                                new_set,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sfof_pkg::VALUE_W-1:0] unique_value,
	output logic [sfof_pkg::POS_W-1:0]          unique_position,
	output logic                                table_overflow
);
	import sfof_pkg::*;

	sfof_cmd_t cmd;
	sfof_sts_t sts;

	// Sequencing.
	sfof_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, compare and output register.
	sfof_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample_value    (sample_value),
		.new_set         (new_set),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.unique_value    (unique_value),
		.unique_position (unique_position),
		.table_overflow  (table_overflow)
	);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the stream first-occurrence filter. It runs a
// short directed table and then random sets of values, with idle cycles on
// both sides. A predictor supplies the expected results of all but typed rows.
// ----------------------------------------------------------------------------
module tb;
	import sfof_pkg::*;

	// One passed value as the output side presents it.
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic               overflow;
	} unique_item_t;

	// One row of stimulus. Typed rows carry their expected outcome directly.
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               starts_set;
		bit                 typed;
		bit                 passes;
		logic [POS_W-1:0]   position;
		logic               overflow;
	} filter_row_t;

	localparam int RANDOM_ITEMS = 850;
	localparam int IDLE_PCT     = 30;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [VALUE_W-1:0]  sample_value;
	logic                       new_set;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [VALUE_W-1:0]  unique_value;
	logic [POS_W-1:0]           unique_position;
	logic                       table_overflow;

	// Predictor state: distinct values of the current set and their count.
	logic [VALUE_W-1:0] seen_tbl [TABLE_DEPTH];
	int unsigned        seen_cnt;

	unique_item_t pending_uniques[$];
	filter_row_t  directed_rows[$];
	int           fail_count;
	bit           quiet;

	stream_first_occurrence_filter_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.new_set        (new_set),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.unique_value   (unique_value),
		.unique_position(unique_position),
		.table_overflow (table_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Works out whether a value is a first occurrence and updates the table.
	function automatic bit first_occurrence_predict(input logic [VALUE_W-1:0] v,
			input logic starts_set, output unique_item_t r);
		bit hit;
		hit = 1'b0;
		r.value    = v;
		r.position = '0;
		r.overflow = 1'b0;
		if (starts_set)
			seen_cnt = 0;
		for (int i = 0; i < seen_cnt; i++) begin
			if (seen_tbl[i] == v)
				hit = 1'b1;
		end
		if (hit)
			return 1'b0;
		r.position = POS_W'(seen_cnt);
		r.overflow = (seen_cnt >= TABLE_DEPTH);
		if (!r.overflow) begin
			seen_tbl[seen_cnt] = v;
			seen_cnt++;
		end
		return 1'b1;
	endfunction

	task automatic add_row(input logic [VALUE_W-1:0] v, input logic starts_set,
			input bit typed, input bit passes, input logic [POS_W-1:0] pos,
			input logic ovf);
		filter_row_t row;
		row.value      = v;
		row.starts_set = starts_set;
		row.typed      = typed;
		row.passes     = passes;
		row.position   = pos;
		row.overflow   = ovf;
		directed_rows.push_back(row);
	endtask

	// Offers one item, holds it until accepted, then records what should pass.
	task automatic send_item(input filter_row_t row);
		unique_item_t predicted;
		bit           passes;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= row.value;
		new_set      <= row.starts_set;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		passes = first_occurrence_predict(row.value, row.starts_set, predicted);
		if (row.typed) begin
			passes             = row.passes;
			predicted.position = row.position;
			predicted.overflow = row.overflow;
		end
		if (passes)
			pending_uniques.push_back(predicted);
	endtask

	// Output side stalls at random, except during the quiet stretch.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		unique_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_uniques.size() == 0) begin
				$error("unexpected result: unique_value %h position %0d overflow %0b",
					unique_value, unique_position, table_overflow);
				fail_count++;
			end else begin
				want = pending_uniques.pop_front();
				if (unique_value !== want.value) begin
					$error("unique_value: expected %h, got %h", want.value, unique_value);
					fail_count++;
				end
				if (unique_position !== want.position) begin
					$error("unique_position: expected %0d, got %0d",
						want.position, unique_position);
					fail_count++;
				end
				if (table_overflow !== want.overflow) begin
					$error("table_overflow: expected %0b, got %0b",
						want.overflow, table_overflow);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [VALUE_W-1:0] pool [32];
		int                 pool_size;
		int                 set_len;
		int                 sent;
		filter_row_t        row;

		fail_count   = 0;
		quiet        = 1'b0;
		seen_cnt     = 0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		sample_value <= '0;
		new_set      <= 1'b0;
		out_stall    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, repeats, a full table and the new set flag.
		add_row(32'h8000_0000, 1'b1, 1, 1, 5'd0, 1'b0);
		add_row(32'h7FFF_FFFF, 1'b0, 1, 1, 5'd1, 1'b0);
		add_row(32'h8000_0000, 1'b0, 1, 0, 5'd0, 1'b0);
		add_row(32'h0000_0000, 1'b0, 1, 1, 5'd2, 1'b0);
		add_row(32'hFFFF_FFFF, 1'b0, 1, 1, 5'd3, 1'b0);
		add_row(32'h7FFF_FFFF, 1'b0, 1, 0, 5'd0, 1'b0);
		for (int i = 1; i <= 12; i++)
			add_row(VALUE_W'(i), 1'b0, 0, 0, 5'd0, 1'b0);
		// The table is full now: new values pass flagged and are not stored.
		add_row(32'h5555_5555, 1'b0, 1, 1, 5'd16, 1'b1);
		add_row(32'h5555_5555, 1'b0, 1, 1, 5'd16, 1'b1);
		add_row(32'hAAAA_AAAA, 1'b0, 1, 1, 5'd16, 1'b1);
		add_row(32'h0000_0005, 1'b0, 1, 0, 5'd0, 1'b0);
		add_row(32'h7FFF_FFFF, 1'b1, 1, 1, 5'd0, 1'b0);
		add_row(32'h7FFF_FFFF, 1'b1, 1, 1, 5'd0, 1'b0);
		add_row(32'h7FFF_FFFF, 1'b0, 1, 0, 5'd0, 1'b0);
		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// Random sets drawn from small pools so that repeats are common; some
		// pools exceed the table to reach overflow, and a few items are noise.
		sent = 0;
		row.typed    = 0;
		row.passes   = 0;
		row.position = '0;
		row.overflow = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 15)
				pool_size = $urandom_range(TABLE_DEPTH + 1, 32);
			else
				pool_size = $urandom_range(1, TABLE_DEPTH - 2);
			for (int k = 0; k < pool_size; k++) begin
				case ($urandom_range(0, 19))
					0: pool[k] = 32'h8000_0000;
					1: pool[k] = 32'h7FFF_FFFF;
					2: pool[k] = 32'hFFFF_FFFF;
					3: pool[k] = 32'h0000_0000;
					default: pool[k] = $urandom;
				endcase
			end
			set_len = $urandom_range(1, 2 * pool_size + 2);
			for (int j = 0; j < set_len; j++) begin
				row.value      = pool[$urandom_range(0, pool_size - 1)];
				row.starts_set = (j == 0) || ($urandom_range(0, 99) < 3);
				if ($urandom_range(0, 99) < 5)
					row.value = $urandom;
				quiet = (sent >= 300) && (sent < 420);
				send_item(row);
				sent++;
			end
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// Drain, then wait for any stray result.
		while (pending_uniques.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sfof_pkg.sv
rtl/sfof_datapath.sv
rtl/sfof_ctrl.sv
rtl/stream_first_occurrence_filter_top.sv
tb/sv/tb.sv
